[rtl/vcpi_pkg.sv]
package vcpi_pkg;

   localparam int VRAM_DEPTH = 16384;
   localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

   localparam logic [3:0] LINE_REG_INDEX = 4'd10;

   localparam logic [7:0] PORT_MASK    = 8'hC1;
   localparam logic [7:0] PORT_VCOUNT  = 8'h40;
   localparam logic [7:0] PORT_HCOUNT  = 8'h41;
   localparam logic [7:0] PORT_DATA    = 8'h80;
   localparam logic [7:0] PORT_CONTROL = 8'h81;

   typedef enum logic [1:0] {
      MODE_VRAM_READ  = 2'd0,
      MODE_VRAM_WRITE = 2'd1,
      MODE_REG_WRITE  = 2'd2,
      MODE_CRAM_WRITE = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] bus_data_out;
      logic       bus_data_driven;
   } rsp_beat_type;

endpackage

[rtl/vcpi_req_if.sv]
interface vcpi_req_if;
   logic       valid;
   logic       ready;
   logic       ioreq_n;
   logic       read_n;
   logic       write_n;
   logic [7:0] port_address;
   logic [7:0] bus_data_in;

   modport source (output valid, ioreq_n, read_n, write_n, port_address, bus_data_in,
                   input ready);
   modport sink   (input valid, ioreq_n, read_n, write_n, port_address, bus_data_in,
                   output ready);
endinterface

[rtl/vcpi_rsp_if.sv]
interface vcpi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bus_data_out;
   logic       bus_data_driven;

   modport source (output valid, bus_data_out, bus_data_driven, input ready);
   modport sink   (input valid, bus_data_out, bus_data_driven, output ready);
endinterface

[rtl/video_chip_port_interface.sv]
// CPU-side port logic of a video display processor. Each request beat is one bus tick and
// yields exactly one response beat; the block takes one beat per cycle, its response written
// to a register in the two-entry response queue, while that queue has room and no clearing
// pass runs. VRAM state is a single-port synchronous memory: each tick does at most one VRAM
// read or write, and the read buffer is taken straight from the memory's registered output
// after a prefetch. After reset a clearing pass writes zero to all 16384 VRAM entries, one per
// cycle; req_chan.ready is low until it ends. Status and CRAM contents never reach the bus.
module video_chip_port_interface
   import vcpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vcpi_req_if.sink    req_chan,
   vcpi_rsp_if.source  rsp_chan
);

   logic [7:0]         vram [VRAM_DEPTH];
   logic [7:0]         vram_rdata_ff;

   logic               clr_ff, clr_in;
   logic [VRAM_AW-1:0] clr_addr_ff, clr_addr_in;

   logic               guard_ff, guard_in;
   logic               pending_ff, pending_in;
   logic [7:0]         first_ff, first_in;
   logic [VRAM_AW-1:0] addr_ff, addr_in;
   mode_type           mode_ff, mode_in;
   logic [7:0]         rb_ff, rb_in;
   logic               rb_mem_ff, rb_mem_in;
   logic [7:0]         line_ff, line_in;
   logic [7:0]         hcount_ff, hcount_in;

   rsp_beat_type       fifo_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff, count_in;

   logic               accept, pop;
   logic               mem_we, mem_re;
   logic [VRAM_AW-1:0] mem_addr;
   logic [7:0]         mem_wdata;
   logic [7:0]         rb_eff;
   logic [VRAM_AW-1:0] addr_next;
   logic [VRAM_AW-1:0] ctrl_addr;
   logic               line_wr;
   logic [7:0]         line_base;
   rsp_beat_type       beat;

   assign req_chan.ready = !clr_ff && (count_ff != 2'd2);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign rb_eff    = rb_mem_ff ? vram_rdata_ff : rb_ff;
   assign addr_next = addr_ff + VRAM_AW'(1);
   assign ctrl_addr = {req_chan.bus_data_in[5:0], first_ff};

   always_comb begin
      guard_in       = guard_ff;
      pending_in     = pending_ff;
      first_in       = first_ff;
      addr_in        = addr_ff;
      mode_in        = mode_ff;
      rb_in          = rb_ff;
      rb_mem_in      = rb_mem_ff;
      hcount_in      = hcount_ff;
      line_wr        = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = addr_ff;
      mem_wdata      = req_chan.bus_data_in;
      beat           = '0;
      clr_in         = clr_ff;
      clr_addr_in    = clr_addr_ff;

      if (accept) begin
         if (guard_ff) begin
            if (req_chan.ioreq_n) begin
               guard_in = 1'b0;
            end
         end else if (!req_chan.ioreq_n && !(req_chan.read_n && req_chan.write_n)) begin
            unique case (req_chan.port_address & PORT_MASK)
               PORT_HCOUNT: begin
                  if (!req_chan.read_n) begin
                     guard_in             = 1'b1;
                     beat.bus_data_out    = {1'b0, hcount_ff[7:1]};
                     beat.bus_data_driven = 1'b1;
                  end
               end
               PORT_VCOUNT: begin
                  if (!req_chan.read_n) begin
                     guard_in             = 1'b1;
                     beat.bus_data_out    = line_ff;
                     beat.bus_data_driven = 1'b1;
                  end
               end
               PORT_CONTROL: begin
                  guard_in = 1'b1;
                  if (!req_chan.read_n) begin
                     pending_in           = 1'b0;
                     beat.bus_data_driven = 1'b1;
                  end else if (!pending_ff) begin
                     first_in   = req_chan.bus_data_in;
                     pending_in = 1'b1;
                  end else begin
                     pending_in = 1'b0;
                     mode_in    = mode_type'(req_chan.bus_data_in[7:6]);
                     addr_in    = ctrl_addr;
                     if (mode_in == MODE_VRAM_READ) begin
                        mem_re    = 1'b1;
                        mem_addr  = ctrl_addr;
                        rb_mem_in = 1'b1;
                     end else if (mode_in == MODE_REG_WRITE &&
                                  req_chan.bus_data_in[3:0] == LINE_REG_INDEX) begin
                        line_wr = 1'b1;
                     end
                  end
               end
               PORT_DATA: begin
                  guard_in   = 1'b1;
                  pending_in = 1'b0;
                  addr_in    = addr_next;
                  if (!req_chan.read_n) begin
                     beat.bus_data_out    = rb_eff;
                     beat.bus_data_driven = 1'b1;
                     mem_re               = 1'b1;
                     mem_addr             = addr_next;
                     rb_mem_in            = 1'b1;
                  end else begin
                     rb_in     = req_chan.bus_data_in;
                     rb_mem_in = 1'b0;
                     mem_we    = (mode_ff != MODE_CRAM_WRITE);
                  end
               end
               default: ;
            endcase
         end
         hcount_in = hcount_ff + 8'd1;
      end

      if (clr_ff) begin
         mem_we      = 1'b1;
         mem_addr    = clr_addr_ff;
         mem_wdata   = 8'd0;
         clr_addr_in = clr_addr_ff + VRAM_AW'(1);
         if (clr_addr_ff == {VRAM_AW{1'b1}}) begin
            clr_in = 1'b0;
         end
      end
   end

   // Line register: load on register write, then count H counter wraps.
   assign line_base = line_wr ? first_ff : line_ff;
   assign line_in   = (accept && hcount_ff == 8'hFF) ? line_base + 8'd1 : line_base;

   assign count_in = count_ff + {1'b0, accept} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         vram_rdata_ff <= vram[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fifo_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         guard_ff    <= 1'b0;
         pending_ff  <= 1'b0;
         first_ff    <= 8'd0;
         addr_ff     <= '0;
         mode_ff     <= MODE_VRAM_READ;
         rb_ff       <= 8'd0;
         rb_mem_ff   <= 1'b0;
         line_ff     <= 8'd0;
         hcount_ff   <= 8'd0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         guard_ff    <= guard_in;
         pending_ff  <= pending_in;
         first_ff    <= first_in;
         addr_ff     <= addr_in;
         mode_ff     <= mode_in;
         rb_ff       <= rb_in;
         rb_mem_ff   <= rb_mem_in;
         line_ff     <= line_in;
         hcount_ff   <= hcount_in;
         wr_ptr_ff   <= wr_ptr_ff ^ accept;
         rd_ptr_ff   <= rd_ptr_ff ^ pop;
         count_ff    <= count_in;
      end
   end

   assign rsp_chan.valid           = (count_ff != 2'd0);
   assign rsp_chan.bus_data_out    = fifo_ff[rd_ptr_ff].bus_data_out;
   assign rsp_chan.bus_data_driven = fifo_ff[rd_ptr_ff].bus_data_driven;

endmodule
